/* rtl/bol_pkg.sv */
package bol_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PREPEND = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP     = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic ins;
        logic ordered;
        logic front;
    } cell_ctrl_t;

endpackage

/* rtl/bol_cell.sv */
module bol_cell (
    input  logic                              clk,
    input  bol_pkg::cell_ctrl_t               ctrl,
    input  logic                              occ,
    input  logic signed [bol_pkg::VALUE_W-1:0] value,
    input  logic signed [bol_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [bol_pkg::VALUE_W-1:0] right_entry,
    input  logic                              hit_in,
    output logic                              hit_out,
    output logic signed [bol_pkg::VALUE_W-1:0] entry
);
    import bol_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      flag_reg;
    logic                      flag_next;

    always_comb
    begin
        if (ctrl.ins)
        begin
            flag_next = !occ || ctrl.front || (ctrl.ordered && (value <= entry_reg));
        end
        else
        begin
            flag_next = occ && (ctrl.front || (entry_reg == value));
        end
    end

    assign hit_out = hit_in || flag_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.upd_en)
        begin
            if (ctrl.ins)
            begin
                if (hit_in)
                begin
                    entry_next = left_entry;
                end
                else if (flag_reg)
                begin
                    entry_next = value;
                end
            end
            else if (hit_out)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.cmp_en)
        begin
            flag_reg <= flag_next;
        end
    end

    assign entry = entry_reg;

endmodule

/* rtl/bounded_ordered_char_list.sv */
// Ordered list of up to CAPACITY signed bytes held in a row of cells, one entry per cell.
// Each request passes through three steps: acceptance, a compare step in which every cell
// compares its entry against the request value, and an update step in which the first hit
// is found along the cell row and entries at and behind it shift one place. in_stall stays
// high through the compare and update steps and while the update step waits for the previous
// result to be taken; the result register lets a new request enter while the previous result
// waits. A new request is taken only once the previous one has left the update step.
module bounded_ordered_char_list #(
    parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bol_pkg::ACTION_W-1:0]       action,
    input  logic signed [bol_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bol_pkg::STATUS_W-1:0]       status,
    output logic [bol_pkg::COUNT_W-1:0]        entry_count
);
    import bol_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic [ACTION_W-1:0]       action_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [CNT_W-1:0]          result_count_reg;
    logic [CNT_W+COUNT_W-1:0]  count_ext;

    cell_ctrl_t                ctrl;
    logic                      is_ins;
    logic                      is_del;
    logic                      is_ordered;
    logic                      is_front;
    logic                      op_ok;
    logic                      out_free;
    logic                      in_take;

    logic                      hit [CAPACITY+1];
    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        is_ins     = 1'b0;
        is_del     = 1'b0;
        is_ordered = 1'b0;
        is_front   = 1'b0;
        case (action_reg)
            ACT_INSERT:
            begin
                is_ins     = 1'b1;
                is_ordered = 1'b1;
            end
            ACT_APPEND:
            begin
                is_ins = 1'b1;
            end
            ACT_PREPEND:
            begin
                is_ins   = 1'b1;
                is_front = 1'b1;
            end
            ACT_DELETE:
            begin
                is_del = 1'b1;
            end
            ACT_POP:
            begin
                is_del   = 1'b1;
                is_front = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status_next = STAT_DONE;
        op_ok       = 1'b0;
        if (is_ins)
        begin
            if (count_reg == CNT_W'(CAPACITY))
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                op_ok = 1'b1;
            end
        end
        else if (is_del)
        begin
            if (count_reg == '0)
            begin
                status_next = STAT_EMPTY;
            end
            else if (!hit[CAPACITY])
            begin
                status_next = STAT_NOT_FOUND;
            end
            else
            begin
                op_ok = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (state_reg == ST_APPLY && out_free && op_ok)
        begin
            if (is_ins)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        ctrl.ins       = is_ins;
        ctrl.ordered   = is_ordered;
        ctrl.front     = is_front;
        ctrl.cmp_en    = (state_reg == ST_CMP);
        ctrl.upd_en    = (state_reg == ST_APPLY) && out_free && op_ok;
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == ST_APPLY && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign hit[0] = 1'b0;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_e;
            logic signed [VALUE_W-1:0] right_e;
            logic                      occ;

            assign occ = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign left_e = value_reg;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_e = cell_entry[i];
            end
            else
            begin : g_body
                assign right_e = cell_entry[i+1];
            end

            bol_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (occ),
                .value       (value_reg),
                .left_entry  (left_e),
                .right_entry (right_e),
                .hit_in      (hit[i]),
                .hit_out     (hit[i+1]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            value_reg  <= value;
        end
        if (state_reg == ST_APPLY && out_free)
        begin
            status_reg       <= status_next;
            result_count_reg <= count_next;
        end
    end

    assign count_ext   = {{COUNT_W{1'b0}}, result_count_reg};
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_ext[COUNT_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_APPLY))
        else $error("entry count changed outside the update cycle");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_APPLY))
        else $error("result raised without an update cycle");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (in_stall && state_reg == ST_CMP))
        else $error("request accepted but compare pass not started");

endmodule

/* tb/bol_list_checker.sv */
`timescale 1ns / 100ps

module bol_list_checker #(
    parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [bol_pkg::ACTION_W-1:0]       action,
    input  logic signed [bol_pkg::VALUE_W-1:0] value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [bol_pkg::STATUS_W-1:0]       status,
    input  logic [bol_pkg::COUNT_W-1:0]        entry_count,
    output int                                 fail_count,
    output int                                 pending
);
    import bol_pkg::*;

    logic signed [VALUE_W-1:0] held [$];
    logic [STATUS_W-1:0]       want_status [$];
    logic [COUNT_W-1:0]        want_count [$];
    logic [STATUS_W-1:0]       exp_status;
    logic [COUNT_W-1:0]        exp_count;
    int                        mismatches = 0;

    function automatic logic [STATUS_W-1:0] apply_request(
        input logic [ACTION_W-1:0]       act,
        input logic signed [VALUE_W-1:0] val
    );
        int                  pos;
        logic [STATUS_W-1:0] st;
        st = STAT_DONE;
        pos = 0;
        case (act)
            ACT_INSERT, ACT_APPEND, ACT_PREPEND:
            begin
                if (held.size() >= CAPACITY)
                    st = STAT_FULL;
                else if (act == ACT_INSERT)
                begin
                    // go in front of the first entry that is not smaller
                    while (pos < held.size() && val > held[pos])
                        pos++;
                    held.insert(pos, val);
                end
                else if (act == ACT_APPEND)
                    held.push_back(val);
                else
                    held.push_front(val);
            end
            ACT_DELETE:
            begin
                if (held.size() == 0)
                    st = STAT_EMPTY;
                else
                begin
                    while (pos < held.size() && held[pos] != val)
                        pos++;
                    if (pos < held.size())
                        held.delete(pos);
                    else
                        st = STAT_NOT_FOUND;
                end
            end
            ACT_POP:
            begin
                if (held.size() == 0)
                    st = STAT_EMPTY;
                else
                    held.delete(0);
            end
            default:
                st = STAT_DONE;
        endcase
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held.delete();
            want_status.delete();
            want_count.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (want_status.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no request pending: status=%0d entry_count=%0d",
                             $time, status, entry_count);
                end
                else
                begin
                    exp_status = want_status.pop_front();
                    exp_count = want_count.pop_front();
                    if (status !== exp_status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, exp_status, status);
                    end
                    if (entry_count !== exp_count)
                    begin
                        mismatches++;
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, exp_count, entry_count);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want_status.push_back(apply_request(action, value));
                want_count.push_back(COUNT_W'(held.size()));
            end
            fail_count <= mismatches;
            pending <= want_status.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import bol_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_FROM   = 600;
    localparam int TAIL_CYCLES  = 12;

    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_stall;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    int                        fail_count;
    int                        pending;
    bit                        quiet;
    bit                        hold_req;

    bounded_ordered_char_list #(
        .CAPACITY(CAPACITY_DEF)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .entry_count(entry_count)
    );

    bol_list_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .entry_count(entry_count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    task automatic send_request(input logic [ACTION_W-1:0] act, input int val);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        value <= VALUE_W'(val);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return int'($urandom_range(0, 6)) - 3;
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0: return -128;
                1: return 127;
                2: return -1;
                default: return 0;
            endcase
        end
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95)
            return ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        if (growing)
        begin
            if (r < 45) return ACT_INSERT;
            if (r < 60) return ACT_APPEND;
            if (r < 75) return ACT_PREPEND;
            if (r < 85) return ACT_DELETE;
            return ACT_POP;
        end
        if (r < 15) return ACT_INSERT;
        if (r < 20) return ACT_APPEND;
        if (r < 25) return ACT_PREPEND;
        if (r < 65) return ACT_DELETE;
        return ACT_POP;
    endfunction

    initial
    begin : receiver
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // hold off long enough to back up the input side
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("bounded_ordered_char_list regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        bit growing;
        int mode_left;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_INSERT;
        value = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        growing = 1'b1;
        mode_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(ACT_POP, 0);
        send_request(ACT_DELETE, 5);
        send_request(ACT_INSERT, 0);
        send_request(ACT_INSERT, 127);
        send_request(ACT_INSERT, -128);
        send_request(ACT_INSERT, 0);
        send_request(ACT_APPEND, -1);
        send_request(ACT_PREPEND, 100);
        send_request(ACT_DELETE, 0);
        send_request(ACT_DELETE, 55);
        send_request(ACT_RSVD_LO, -86);
        send_request(ACT_RSVD_HI, 85);
        // five entries held here; fill up, then push into the full list
        repeat (CAPACITY_DEF - 5)
        begin
            case ($urandom_range(0, 2))
                0: send_request(ACT_INSERT, pick_value());
                1: send_request(ACT_APPEND, pick_value());
                default: send_request(ACT_PREPEND, pick_value());
            endcase
        end
        send_request(ACT_INSERT, 7);
        send_request(ACT_APPEND, -7);
        send_request(ACT_PREPEND, 1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (mode_left == 0)
            begin
                growing = !growing;
                mode_left = $urandom_range(15, 40);
            end
            mode_left--;
            if (i == HOLD_AT)
                hold_req <= 1'b1;
            if (i == QUIET_FROM)
                quiet <= 1'b1;
            send_request(pick_action(growing), pick_value());
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bounded_ordered_char_list regression: pass");
        else
            $display("bounded_ordered_char_list regression: fail");
        $finish;
    end

endmodule
